FILE: rtl/mvm_pkg.sv
// ----------------------------------------------------------------------------
// mvm_pkg
// Shared types and constants of the matrix vector multiply core.
// ----------------------------------------------------------------------------
package mvm_pkg;

   localparam int VALUE_W = 16;
   localparam int PROD_W  = 32;
   localparam int ACC_W   = 40;
   localparam int IDX_W   = 6;
   localparam int CFG_W   = 7;

   localparam logic FUNC_WEIGHT = 1'b0;
   localparam logic FUNC_VECTOR = 1'b1;

   localparam logic REG_ROWS = 1'b0;
   localparam logic REG_COLS = 1'b1;

   typedef struct packed {
      logic rd;
      logic wr;
      logic mac;
      logic load;
      logic shift;
   } cell_ctrl_type;

endpackage

FILE: rtl/mvm_cell.sv
// ----------------------------------------------------------------------------
// mvm_cell
// One matrix row: weight memory, multiplier, accumulator and result shift stage.
// ----------------------------------------------------------------------------
module mvm_cell #(
   parameter int ROW_ID   = 0,
   parameter int MAX_COLS = 64,
   parameter int COL_AW   = 6
) (
   input  logic                                clock,
   input  logic                                reset,
   input  mvm_pkg::cell_ctrl_type              ctrl,
   input  logic [mvm_pkg::IDX_W-1:0]           row,
   input  logic [COL_AW-1:0]                   addr,
   input  logic signed [mvm_pkg::VALUE_W-1:0]  wdata,
   input  logic signed [mvm_pkg::VALUE_W-1:0]  elem,
   input  logic signed [mvm_pkg::ACC_W-1:0]    shift_in,
   output logic signed [mvm_pkg::ACC_W-1:0]    shift_out
);
   import mvm_pkg::*;

   logic signed [VALUE_W-1:0] mem [MAX_COLS];
   logic signed [VALUE_W-1:0] rdata_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [ACC_W-1:0]   acc_ff;
   logic signed [ACC_W-1:0]   acc_in;
   logic signed [ACC_W-1:0]   out_ff;
   logic signed [ACC_W-1:0]   out_in;
   logic signed [ACC_W-1:0]   sum;

   always_ff @(posedge clock) begin
      if (ctrl.wr && (32'(row) == ROW_ID)) begin
         mem[addr] <= wdata;
      end
      if (ctrl.rd) begin
         rdata_ff <= mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(rdata_ff * elem);
   end

   assign sum = acc_ff + ACC_W'(prod_ff);

   always_comb begin
      acc_in = acc_ff;
      out_in = out_ff;
      if (ctrl.load) begin
         acc_in = '0;
         out_in = sum;
      end else begin
         if (ctrl.mac) begin
            acc_in = sum;
         end
         if (ctrl.shift) begin
            out_in = shift_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
      out_ff <= out_in;
   end

   assign shift_out = out_ff;

endmodule

FILE: rtl/matrix_vector_multiply_core.sv
// ----------------------------------------------------------------------------
// matrix_vector_multiply_core
// Stored weight matrix times a streamed vector, one cell per row.
// ----------------------------------------------------------------------------
// The first result is valid after last1_ff, last2_ff and the load to out_ff.
// Throughput: one request per cycle; after the last column the block takes no
// request until all nrows results shifted out, one per cycle with rsp_ready.
// Results leave through the cell chain, set by the per-cell shift stage.
// Reset clears accumulators, counters and valid flags; weights stay undefined.
module matrix_vector_multiply_core #(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_func,
   input  logic [mvm_pkg::IDX_W-1:0]           req_row,
   input  logic [mvm_pkg::IDX_W-1:0]           req_col,
   input  logic signed [mvm_pkg::VALUE_W-1:0]  req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [mvm_pkg::IDX_W-1:0]           rsp_row_index,
   output logic signed [mvm_pkg::ACC_W-1:0]    rsp_dot,
   output logic                                rsp_last_row,
   input  logic                                csr_we,
   input  logic                                csr_index,
   input  logic [mvm_pkg::CFG_W-1:0]           csr_wdata
);
   import mvm_pkg::*;

   localparam int COL_AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int RCNT_W = $clog2(MAX_ROWS + 1);
   localparam int CCNT_W = $clog2(MAX_COLS + 1);

   logic [CFG_W-1:0]    rows_ff;
   logic [CFG_W-1:0]    cols_ff;
   logic [RCNT_W-1:0]   nrows;
   logic [CCNT_W-1:0]   ncols;
   logic                accept;
   logic                mac0;
   logic                last0;
   logic                mac1_ff;
   logic                last1_ff;
   logic                mac2_ff;
   logic                last2_ff;
   logic signed [VALUE_W-1:0] val1_ff;
   logic [RCNT_W-1:0]   remain_ff;
   logic [RCNT_W-1:0]   remain_in;
   logic [IDX_W-1:0]    idx_ff;
   logic [IDX_W-1:0]    idx_in;
   logic                shift;
   cell_ctrl_type       ctrl;
   logic signed [ACC_W-1:0] chain [MAX_ROWS+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= CFG_W'(64);
         cols_ff <= CFG_W'(64);
      end else if (csr_we) begin
         case (csr_index)
            REG_ROWS: rows_ff <= csr_wdata;
            REG_COLS: cols_ff <= csr_wdata;
            default:  rows_ff <= rows_ff;
         endcase
      end
   end

   always_comb begin
      if (rows_ff == '0) begin
         nrows = RCNT_W'(1);
      end else if (32'(rows_ff) > MAX_ROWS) begin
         nrows = RCNT_W'(MAX_ROWS);
      end else begin
         nrows = RCNT_W'(rows_ff);
      end
      if (cols_ff == '0) begin
         ncols = CCNT_W'(1);
      end else if (32'(cols_ff) > MAX_COLS) begin
         ncols = CCNT_W'(MAX_COLS);
      end else begin
         ncols = CCNT_W'(cols_ff);
      end
   end

   assign req_ready = (remain_ff == '0) && !last1_ff && !last2_ff;
   assign accept    = req_valid && req_ready;
   assign mac0      = accept && (req_func == FUNC_VECTOR) && (32'(req_col) < 32'(ncols));
   assign last0     = mac0 && (32'(req_col) == 32'(ncols) - 1);
   assign shift     = rsp_valid && rsp_ready;

   always_comb begin
      ctrl.rd    = mac0;
      ctrl.wr    = accept && (req_func == FUNC_WEIGHT) && (32'(req_row) < MAX_ROWS)
                   && (32'(req_col) < MAX_COLS);
      ctrl.mac   = mac2_ff;
      ctrl.load  = last2_ff;
      ctrl.shift = shift;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mac1_ff  <= 1'b0;
         last1_ff <= 1'b0;
         mac2_ff  <= 1'b0;
         last2_ff <= 1'b0;
      end else begin
         mac1_ff  <= mac0;
         last1_ff <= last0;
         mac2_ff  <= mac1_ff;
         last2_ff <= last1_ff;
      end
      val1_ff <= req_value;
   end

   always_comb begin
      remain_in = remain_ff;
      idx_in    = idx_ff;
      if (last2_ff) begin
         remain_in = nrows;
         idx_in    = '0;
      end else if (shift) begin
         remain_in = remain_ff - RCNT_W'(1);
         idx_in    = idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remain_ff <= '0;
         idx_ff    <= '0;
      end else begin
         remain_ff <= remain_in;
         idx_ff    <= idx_in;
      end
   end

   assign chain[MAX_ROWS] = '0;

   for (genvar g = 0; g < MAX_ROWS; g++) begin : g_cell
      mvm_cell #(
         .ROW_ID   (g),
         .MAX_COLS (MAX_COLS),
         .COL_AW   (COL_AW)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .row       (req_row),
         .addr      (COL_AW'(req_col)),
         .wdata     (req_value),
         .elem      (val1_ff),
         .shift_in  (chain[g+1]),
         .shift_out (chain[g])
      );
   end

   assign rsp_valid     = (remain_ff != '0);
   assign rsp_dot       = chain[0];
   assign rsp_row_index = idx_ff;
   assign rsp_last_row  = (remain_ff == RCNT_W'(1));

endmodule

FILE: rtl/mvm_checker.sv
// ----------------------------------------------------------------------------
// mvm_checker
// Port-level checks of the matrix vector multiply core, bound to the top level.
// ----------------------------------------------------------------------------
module mvm_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [mvm_pkg::IDX_W-1:0]           rsp_row_index,
   input logic signed [mvm_pkg::ACC_W-1:0]    rsp_dot,
   input logic                                rsp_last_row
);
   import mvm_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_dot)
         && $stable(rsp_row_index) && $stable(rsp_last_row))
      else $error("Result changed while stalled.");

   a_no_req_while_draining: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("Request taken while results are pending.");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last_row |=> !rsp_valid)
      else $error("Result shown after the final row.");

   a_row_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_row |=> rsp_valid
         && (rsp_row_index == IDX_W'($past(rsp_row_index) + IDX_W'(1))))
      else $error("Rows not delivered in order.");

endmodule

bind matrix_vector_multiply_core mvm_checker u_mvm_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_row_index (rsp_row_index),
   .rsp_dot       (rsp_dot),
   .rsp_last_row  (rsp_last_row)
);
